### hdl/tbv6_pkg.sv
package tbv6_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    // Item kinds carried on the action field.
    localparam logic ACT_VOXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Bit positions inside a stored label pair.
    localparam int WHITE_BIT = 0;
    localparam int GRAY_BIT  = 1;

    localparam int SIZE_XY_W  = 8;
    localparam int SIZE_Z_W   = 9;
    localparam int SIZE_X_RST = 128;
    localparam int SIZE_Y_RST = 128;
    localparam int SIZE_Z_RST = 256;

    typedef logic [1:0]          cfg_index_t;
    typedef logic [SIZE_Z_W-1:0] cfg_data_t;
    typedef logic [1:0]          label_t;
    typedef logic [6:0]          out_x_t;
    typedef logic [6:0]          out_y_t;
    typedef logic [7:0]          out_z_t;

    // Which neighbor reads fall inside the volume.
    typedef struct packed {
        logic cen;
        logic below;
        logic xp;
        logic xm;
        logic ysame;
        logic yother;
    } nb_ok_t;

endpackage

### hdl/tbv6_ring.sv
module tbv6_ring #(
    parameter int MAX_X = 128,
    parameter int MAX_Y = 128,
    localparam int XW = $clog2(MAX_X),
    localparam int DEPTH = (MAX_Y + 3) / 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic                wr_bank,
    input  logic [AW-1:0]       wr_addr,
    input  logic                wr_row,
    input  logic                wr_par,
    input  logic [XW-1:0]       wr_x,
    input  tbv6_pkg::label_t    wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr0,
    input  logic [AW-1:0]       rd_addr1,
    input  logic                rd_cbank,
    input  logic                rd_row,
    input  logic                rd_par,
    input  logic [XW-1:0]       rd_x,
    input  logic [XW-1:0]       rd_xp,
    input  logic [XW-1:0]       rd_xm,
    input  tbv6_pkg::nb_ok_t    rd_ok,
    input  tbv6_pkg::label_t    rd_above,
    output logic                white_edge,
    output logic                gray_edge
);

    // One word holds two adjacent rows, each for both slice parities.
    // Row pairs alternate between the two banks, so rows y-1, y and y+1
    // always come from one word in each bank.
    typedef logic [1:0][1:0][MAX_X-1:0][1:0] word_t;

    word_t bank0_mem [DEPTH];
    word_t bank1_mem [DEPTH];

    word_t               rd0_reg;
    word_t               rd1_reg;
    logic                cbank_reg;
    logic                row_reg;
    logic                par_reg;
    logic [XW-1:0]       x_reg;
    logic [XW-1:0]       xp_reg;
    logic [XW-1:0]       xm_reg;
    tbv6_pkg::nb_ok_t    ok_reg;
    tbv6_pkg::label_t    above_reg;

    word_t               word_c;
    word_t               word_o;
    tbv6_pkg::label_t    centre;
    tbv6_pkg::label_t    below;
    tbv6_pkg::label_t    nb_xp;
    tbv6_pkg::label_t    nb_xm;
    tbv6_pkg::label_t    nb_ys;
    tbv6_pkg::label_t    nb_yo;
    logic                white_all;
    logic                union_gap;

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_bank)
        begin
            bank0_mem[wr_addr][wr_row][wr_par][wr_x] <= wr_data;
        end
        if (rd_en)
        begin
            rd0_reg <= bank0_mem[rd_addr0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_bank)
        begin
            bank1_mem[wr_addr][wr_row][wr_par][wr_x] <= wr_data;
        end
        if (rd_en)
        begin
            rd1_reg <= bank1_mem[rd_addr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cbank_reg <= rd_cbank;
            row_reg   <= rd_row;
            par_reg   <= rd_par;
            x_reg     <= rd_x;
            xp_reg    <= rd_xp;
            xm_reg    <= rd_xm;
            ok_reg    <= rd_ok;
            above_reg <= rd_above;
        end
    end

    always_comb
    begin
        word_c = cbank_reg ? rd1_reg : rd0_reg;
        word_o = cbank_reg ? rd0_reg : rd1_reg;
        centre = ok_reg.cen    ? word_c[row_reg][par_reg][x_reg]   : '0;
        below  = ok_reg.below  ? word_c[row_reg][~par_reg][x_reg]  : '0;
        nb_xp  = ok_reg.xp     ? word_c[row_reg][par_reg][xp_reg]  : '0;
        nb_xm  = ok_reg.xm     ? word_c[row_reg][par_reg][xm_reg]  : '0;
        nb_ys  = ok_reg.ysame  ? word_c[~row_reg][par_reg][x_reg]  : '0;
        nb_yo  = ok_reg.yother ? word_o[~row_reg][par_reg][x_reg]  : '0;

        white_all = nb_xp[tbv6_pkg::WHITE_BIT] & nb_xm[tbv6_pkg::WHITE_BIT]
                  & nb_ys[tbv6_pkg::WHITE_BIT] & nb_yo[tbv6_pkg::WHITE_BIT]
                  & above_reg[tbv6_pkg::WHITE_BIT] & below[tbv6_pkg::WHITE_BIT];
        union_gap = (nb_xp == '0) | (nb_xm == '0) | (nb_ys == '0) | (nb_yo == '0)
                  | (above_reg == '0) | (below == '0);

        white_edge = centre[tbv6_pkg::WHITE_BIT] & ~white_all;
        gray_edge  = centre[tbv6_pkg::GRAY_BIT] & union_gap;
    end

endmodule

### hdl/tissue_boundary_volume_6n_top.sv
// Streaming 6-connected boundary extraction: one request (a voxel in raster order with its
// white and gray labels, or a drain tick) is taken every clock cycle, and a voxel's result
// passes the read stage and the result register after the voxel one slice above it arrives;
// drain ticks then flush the last slice one voxel per tick. The rate is set by the label
// store, two banks of row-pair words each read at one address per cycle, which deliver
// a voxel's whole neighborhood in one access while the incoming label is written beside it.
// The store needs no clearing after reset; a voxel is only read after it was written.
// A held result stalls requests only once the stage in front of it is also full.
module tissue_boundary_volume_6n_top #(
    parameter int MAX_X = 128,
    parameter int MAX_Y = 128,
    parameter int MAX_Z = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  action,
    input  logic                  white_voxel,
    input  logic                  gray_voxel,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  white_edge,
    output logic                  gray_edge,
    output tbv6_pkg::out_x_t      out_x,
    output tbv6_pkg::out_y_t      out_y,
    output tbv6_pkg::out_z_t      out_z,
    output logic                  last_voxel,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  tbv6_pkg::cfg_index_t  cfg_index,
    input  tbv6_pkg::cfg_data_t   cfg_data
);

    localparam int XW    = $clog2(MAX_X);
    localparam int YW    = $clog2(MAX_Y);
    localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int CXW   = XW + 1;
    localparam int CYW   = YW + 1;
    localparam int CZW   = ZW + 1;
    localparam int DEPTH = (MAX_Y + 3) / 4;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SX_RST = (tbv6_pkg::SIZE_X_RST > MAX_X) ? MAX_X : tbv6_pkg::SIZE_X_RST;
    localparam int SY_RST = (tbv6_pkg::SIZE_Y_RST > MAX_Y) ? MAX_Y : tbv6_pkg::SIZE_Y_RST;
    localparam int SZ_RST = (tbv6_pkg::SIZE_Z_RST > MAX_Z) ? MAX_Z : tbv6_pkg::SIZE_Z_RST;

    logic [CXW-1:0] sx_reg, sx_next;
    logic [CYW-1:0] sy_reg, sy_next;
    logic [CZW-1:0] sz_reg, sz_next;
    logic [CXW-1:0] cfg_sx;
    logic [CYW-1:0] cfg_sy;
    logic [CZW-1:0] cfg_sz;
    logic [tbv6_pkg::SIZE_XY_W-1:0] cfg_xy_raw;

    logic [XW-1:0] in_x_reg, in_x_next;
    logic [YW-1:0] in_y_reg, in_y_next;
    logic [ZW-1:0] in_z_reg, in_z_next;
    logic [XW-1:0] emit_x_reg, emit_x_next;
    logic [YW-1:0] emit_y_reg, emit_y_next;
    logic [ZW-1:0] emit_z_reg, emit_z_next;
    logic          complete_reg, complete_next;

    logic          s1_valid_reg, s1_valid_next;
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    logic [ZW-1:0] s1_z_reg;
    logic          s1_last_reg;

    logic              result_valid_reg, result_valid_next;
    logic              white_edge_reg;
    logic              gray_edge_reg;
    tbv6_pkg::out_x_t  out_x_reg;
    tbv6_pkg::out_y_t  out_y_reg;
    tbv6_pkg::out_z_t  out_z_reg;
    logic              last_reg;

    logic item_accept;
    logic is_drain;
    logic produce;
    logic do_write;
    logic out_load;
    logic ring_white;
    logic ring_gray;
    tbv6_pkg::label_t labels;
    tbv6_pkg::label_t above;

    logic ex_last, ey_last, ez_last, emit_done;
    logic ix_last, iy_last, iz_last;
    logic ex_in, ey_in, xm_in, ym_in;
    logic [CYW-1:0] kc, ko, kw;
    logic [AW-1:0]  addr_c, addr_o;
    tbv6_pkg::nb_ok_t nb_ok;

    // Configuration: sizes are kept already clamped to 1..MAX.
    assign cfg_ready  = 1'b1;
    assign cfg_xy_raw = cfg_data[tbv6_pkg::SIZE_XY_W-1:0];

    always_comb
    begin
        cfg_sx = CXW'(MAX_X);
        if (cfg_xy_raw == '0)
        begin
            cfg_sx = CXW'(1);
        end
        else if (int'(cfg_xy_raw) <= MAX_X)
        begin
            cfg_sx = CXW'(cfg_xy_raw);
        end

        cfg_sy = CYW'(MAX_Y);
        if (cfg_xy_raw == '0)
        begin
            cfg_sy = CYW'(1);
        end
        else if (int'(cfg_xy_raw) <= MAX_Y)
        begin
            cfg_sy = CYW'(cfg_xy_raw);
        end

        cfg_sz = CZW'(MAX_Z);
        if (cfg_data == '0)
        begin
            cfg_sz = CZW'(1);
        end
        else if (int'(cfg_data) <= MAX_Z)
        begin
            cfg_sz = CZW'(cfg_data);
        end

        sx_next = sx_reg;
        sy_next = sy_reg;
        sz_next = sz_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tbv6_pkg::REG_SIZE_X: sx_next = cfg_sx;
                tbv6_pkg::REG_SIZE_Y: sy_next = cfg_sy;
                tbv6_pkg::REG_SIZE_Z: sz_next = cfg_sz;
                default: ;
            endcase
        end
    end

    // Request handshake and pipeline flow.
    assign out_load    = !result_valid_reg || !result_stall;
    assign item_stall  = s1_valid_reg && !out_load;
    assign item_accept = item_valid && !item_stall;
    assign is_drain    = (action == tbv6_pkg::ACT_DRAIN);
    assign labels      = {gray_voxel, white_voxel};
    assign above       = is_drain ? '0 : labels;

    assign ex_last   = (CXW'(emit_x_reg) + CXW'(1)) >= sx_reg;
    assign ey_last   = (CYW'(emit_y_reg) + CYW'(1)) >= sy_reg;
    assign ez_last   = (CZW'(emit_z_reg) + CZW'(1)) >= sz_reg;
    assign emit_done = ex_last && ey_last && ez_last;
    assign ix_last   = (CXW'(in_x_reg) + CXW'(1)) >= sx_reg;
    assign iy_last   = (CYW'(in_y_reg) + CYW'(1)) >= sy_reg;
    assign iz_last   = (CZW'(in_z_reg) + CZW'(1)) >= sz_reg;

    assign produce  = is_drain ? complete_reg : (!complete_reg && (in_z_reg != '0));
    assign do_write = !is_drain && !complete_reg && !(produce && emit_done);

    always_comb
    begin
        in_x_next     = in_x_reg;
        in_y_next     = in_y_reg;
        in_z_next     = in_z_reg;
        emit_x_next   = emit_x_reg;
        emit_y_next   = emit_y_reg;
        emit_z_next   = emit_z_reg;
        complete_next = complete_reg;

        if (item_accept && produce)
        begin
            if (emit_done)
            begin
                // The volume is finished: start over for the next one.
                in_x_next     = '0;
                in_y_next     = '0;
                in_z_next     = '0;
                emit_x_next   = '0;
                emit_y_next   = '0;
                emit_z_next   = '0;
                complete_next = 1'b0;
            end
            else if (!ex_last)
            begin
                emit_x_next = emit_x_reg + XW'(1);
            end
            else
            begin
                emit_x_next = '0;
                if (!ey_last)
                begin
                    emit_y_next = emit_y_reg + YW'(1);
                end
                else
                begin
                    emit_y_next = '0;
                    emit_z_next = emit_z_reg + ZW'(1);
                end
            end
        end

        if (item_accept && do_write)
        begin
            if (!ix_last)
            begin
                in_x_next = in_x_reg + XW'(1);
            end
            else
            begin
                in_x_next = '0;
                if (!iy_last)
                begin
                    in_y_next = in_y_reg + YW'(1);
                end
                else
                begin
                    in_y_next = '0;
                    if (!iz_last)
                    begin
                        in_z_next = in_z_reg + ZW'(1);
                    end
                    else
                    begin
                        in_z_next     = '0;
                        complete_next = 1'b1;
                    end
                end
            end
        end
    end

    // Neighborhood of the voxel being emitted. Row pair kc holds the voxel;
    // the row pair beyond it (above for odd rows, below for even rows) sits
    // in the other bank.
    assign kc = CYW'(emit_y_reg) >> 1;
    assign ko = emit_y_reg[0] ? (kc + CYW'(1)) : (kc - CYW'(1));
    assign kw = CYW'(in_y_reg) >> 1;
    assign addr_c = AW'(kc >> 1);
    assign addr_o = AW'(ko >> 1);

    assign ex_in = CXW'(emit_x_reg) < sx_reg;
    assign ey_in = CYW'(emit_y_reg) < sy_reg;
    assign xm_in = (emit_x_reg != '0) && ((CXW'(emit_x_reg) - CXW'(1)) < sx_reg);
    assign ym_in = (emit_y_reg != '0) && ((CYW'(emit_y_reg) - CYW'(1)) < sy_reg);

    always_comb
    begin
        nb_ok.cen    = ex_in && ey_in;
        nb_ok.below  = ex_in && ey_in && (emit_z_reg != '0);
        nb_ok.xp     = !ex_last && ey_in;
        nb_ok.xm     = xm_in && ey_in;
        nb_ok.ysame  = ex_in && (emit_y_reg[0] ? ym_in : !ey_last);
        nb_ok.yother = ex_in && (emit_y_reg[0] ? !ey_last : ym_in);
    end

    tbv6_ring #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_ring (
        .clk        (clk),
        .wr_en      (item_accept && do_write),
        .wr_bank    (kw[0]),
        .wr_addr    (AW'(kw >> 1)),
        .wr_row     (in_y_reg[0]),
        .wr_par     (in_z_reg[0]),
        .wr_x       (in_x_reg),
        .wr_data    (labels),
        .rd_en      (item_accept),
        .rd_addr0   (kc[0] ? addr_o : addr_c),
        .rd_addr1   (kc[0] ? addr_c : addr_o),
        .rd_cbank   (kc[0]),
        .rd_row     (emit_y_reg[0]),
        .rd_par     (emit_z_reg[0]),
        .rd_x       (emit_x_reg),
        .rd_xp      (emit_x_reg + XW'(1)),
        .rd_xm      (emit_x_reg - XW'(1)),
        .rd_ok      (nb_ok),
        .rd_above   (above),
        .white_edge (ring_white),
        .gray_edge  (ring_gray)
    );

    always_comb
    begin
        if (item_accept)
        begin
            s1_valid_next = produce;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        result_valid_next = out_load ? s1_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg           <= CXW'(SX_RST);
            sy_reg           <= CYW'(SY_RST);
            sz_reg           <= CZW'(SZ_RST);
            in_x_reg         <= '0;
            in_y_reg         <= '0;
            in_z_reg         <= '0;
            emit_x_reg       <= '0;
            emit_y_reg       <= '0;
            emit_z_reg       <= '0;
            complete_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sx_reg           <= sx_next;
            sy_reg           <= sy_next;
            sz_reg           <= sz_next;
            in_x_reg         <= in_x_next;
            in_y_reg         <= in_y_next;
            in_z_reg         <= in_z_next;
            emit_x_reg       <= emit_x_next;
            emit_y_reg       <= emit_y_next;
            emit_z_reg       <= emit_z_next;
            complete_reg     <= complete_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && produce)
        begin
            s1_x_reg    <= emit_x_reg;
            s1_y_reg    <= emit_y_reg;
            s1_z_reg    <= emit_z_reg;
            s1_last_reg <= emit_done;
        end
        if (out_load && s1_valid_reg)
        begin
            white_edge_reg <= ring_white;
            gray_edge_reg  <= ring_gray;
            out_x_reg      <= tbv6_pkg::out_x_t'(s1_x_reg);
            out_y_reg      <= tbv6_pkg::out_y_t'(s1_y_reg);
            out_z_reg      <= tbv6_pkg::out_z_t'(s1_z_reg);
            last_reg       <= s1_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign white_edge   = white_edge_reg;
    assign gray_edge    = gray_edge_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_z        = out_z_reg;
    assign last_voxel   = last_reg;

endmodule

### hdl/tbv6_checker.sv
module tbv6_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic              white_edge,
    input  logic              gray_edge,
    input  tbv6_pkg::out_x_t  out_x,
    input  tbv6_pkg::out_y_t  out_y,
    input  tbv6_pkg::out_z_t  out_z,
    input  logic              last_voxel
);

    // A new result always stems from an earlier request, carried through the read stage into the result register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
    else $error("result appeared without a request two cycles before");

    // Requests are only held back while a finished result is itself held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
    else $error("request stalled while the result register could drain");

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable({white_edge, gray_edge, out_x, out_y, out_z,
                                      last_voxel})))
    else $error("stalled result changed");

endmodule

bind tissue_boundary_volume_6n_top tbv6_checker u_tbv6_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .white_edge   (white_edge),
    .gray_edge    (gray_edge),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .last_voxel   (last_voxel)
);

### tb/sv/tissue_boundary_volume_6n_top_tb.sv
`timescale 1ns / 1ps

module tissue_boundary_volume_6n_top_tb;

    localparam int MAX_X = 128;
    localparam int MAX_Y = 128;
    localparam int MAX_Z = 256;

    localparam tbv6_pkg::cfg_index_t REG_UNUSED  = tbv6_pkg::cfg_index_t'(3);
    localparam tbv6_pkg::label_t     BACKGROUND  = '0;
    localparam int unsigned          ITEM_TARGET = 1700;
    localparam int unsigned          QUIET_TAIL  = 150;
    localparam int unsigned          HOLD_CYCLES = 300;
    localparam int unsigned          SETTLE      = 16;
    localparam int unsigned          CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic             white_edge;
        logic             gray_edge;
        tbv6_pkg::out_x_t out_x;
        tbv6_pkg::out_y_t out_y;
        tbv6_pkg::out_z_t out_z;
        logic             last_voxel;
    } edge_result_t;

    // Tracks the two newest slices of labels and predicts the edge flags of each voxel.
    class boundary_checker;
        tbv6_pkg::label_t slices [0:1][0:MAX_Y-1][0:MAX_X-1];
        int unsigned      size_x, size_y, size_z;
        int unsigned      in_x, in_y, in_z;
        int unsigned      emit_x, emit_y, emit_z;
        bit               input_done;
        edge_result_t     pending_edges [$];
        int unsigned      errors;

        function new();
            foreach (slices[p, y, x])
                slices[p][y][x] = BACKGROUND;
            size_x = tbv6_pkg::SIZE_X_RST;
            size_y = tbv6_pkg::SIZE_Y_RST;
            size_z = tbv6_pkg::SIZE_Z_RST;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_x = 0;
            in_y = 0;
            in_z = 0;
            emit_x = 0;
            emit_y = 0;
            emit_z = 0;
            input_done = 1'b0;
        endfunction

        function void set_register(tbv6_pkg::cfg_index_t idx, tbv6_pkg::cfg_data_t val);
            case (idx)
                tbv6_pkg::REG_SIZE_X: size_x = 32'(val[tbv6_pkg::SIZE_XY_W-1:0]);
                tbv6_pkg::REG_SIZE_Y: size_y = 32'(val[tbv6_pkg::SIZE_XY_W-1:0]);
                tbv6_pkg::REG_SIZE_Z: size_z = 32'(val);
                default: ;
            endcase
        endfunction

        function int unsigned fit(int unsigned v, int unsigned top);
            if (v == 0)
                return 1;
            return (v > top) ? top : v;
        endfunction

        // Size of the volume along one axis, as the block actually uses it.
        function int unsigned span(tbv6_pkg::cfg_index_t idx);
            case (idx)
                tbv6_pkg::REG_SIZE_X: return fit(size_x, MAX_X);
                tbv6_pkg::REG_SIZE_Y: return fit(size_y, MAX_Y);
                default:              return fit(size_z, MAX_Z);
            endcase
        endfunction

        function int pending();
            return pending_edges.size();
        endfunction

        // Anything outside the slice reads as background.
        function tbv6_pkg::label_t label_at(bit par, int x, int y, int unsigned sx,
                                            int unsigned sy);
            if (x < 0 || y < 0 || x >= int'(sx) || y >= int'(sy))
                return BACKGROUND;
            return slices[par][y % MAX_Y][x % MAX_X];
        endfunction

        function edge_result_t edges_at_emit(tbv6_pkg::label_t above, int unsigned sx,
                                             int unsigned sy, int unsigned sz);
            tbv6_pkg::label_t nb [6];
            tbv6_pkg::label_t centre;
            bit               cur;
            bit               white_open;
            bit               union_open;
            int               x;
            int               y;
            edge_result_t     r;
            cur = emit_z[0];
            x = int'(emit_x);
            y = int'(emit_y);
            centre = label_at(cur, x, y, sx, sy);
            nb[0] = label_at(cur, x + 1, y, sx, sy);
            nb[1] = label_at(cur, x - 1, y, sx, sy);
            nb[2] = label_at(cur, x, y + 1, sx, sy);
            nb[3] = label_at(cur, x, y - 1, sx, sy);
            nb[4] = above;
            nb[5] = (emit_z == 0) ? BACKGROUND : label_at(!cur, x, y, sx, sy);
            white_open = 1'b0;
            union_open = 1'b0;
            foreach (nb[i])
            begin
                if (!nb[i][tbv6_pkg::WHITE_BIT])
                    white_open = 1'b1;
                if (nb[i] == BACKGROUND)
                    union_open = 1'b1;
            end
            r.white_edge = centre[tbv6_pkg::WHITE_BIT] && white_open;
            r.gray_edge  = centre[tbv6_pkg::GRAY_BIT] && union_open;
            r.out_x      = tbv6_pkg::out_x_t'(emit_x);
            r.out_y      = tbv6_pkg::out_y_t'(emit_y);
            r.out_z      = tbv6_pkg::out_z_t'(emit_z);
            r.last_voxel = (emit_x + 1 >= sx) && (emit_y + 1 >= sy) && (emit_z + 1 >= sz);
            return r;
        endfunction

        // Returns 1 once the whole volume has been reported.
        function bit step_emit(int unsigned sx, int unsigned sy, int unsigned sz);
            if (emit_x + 1 < sx)
            begin
                emit_x++;
                return 1'b0;
            end
            emit_x = 0;
            if (emit_y + 1 < sy)
            begin
                emit_y++;
                return 1'b0;
            end
            emit_y = 0;
            if (emit_z + 1 < sz)
            begin
                emit_z++;
                return 1'b0;
            end
            emit_z = 0;
            return 1'b1;
        endfunction

        function void note_request(logic act, logic white, logic gray);
            int unsigned      sx;
            int unsigned      sy;
            int unsigned      sz;
            tbv6_pkg::label_t lab;
            sx = span(tbv6_pkg::REG_SIZE_X);
            sy = span(tbv6_pkg::REG_SIZE_Y);
            sz = span(tbv6_pkg::REG_SIZE_Z);
            lab = '0;
            lab[tbv6_pkg::WHITE_BIT] = white;
            lab[tbv6_pkg::GRAY_BIT] = gray;
            if (act == tbv6_pkg::ACT_DRAIN)
            begin
                if (!input_done)
                    return;
                pending_edges.push_back(edges_at_emit(BACKGROUND, sx, sy, sz));
                if (step_emit(sx, sy, sz))
                    restart();
                return;
            end
            if (input_done)
                return;
            if (in_z != 0)
            begin
                pending_edges.push_back(edges_at_emit(lab, sx, sy, sz));
                if (step_emit(sx, sy, sz))
                begin
                    restart();
                    return;
                end
            end
            slices[in_z[0]][in_y % MAX_Y][in_x % MAX_X] = lab;
            if (in_x + 1 < sx)
            begin
                in_x++;
            end
            else
            begin
                in_x = 0;
                if (in_y + 1 < sy)
                begin
                    in_y++;
                end
                else
                begin
                    in_y = 0;
                    if (in_z + 1 < sz)
                    begin
                        in_z++;
                    end
                    else
                    begin
                        in_z = 0;
                        input_done = 1'b1;
                    end
                end
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(edge_result_t got);
            edge_result_t want;
            if (pending_edges.size() == 0)
            begin
                $error("result for (%0d,%0d,%0d) with none expected",
                       got.out_x, got.out_y, got.out_z);
                errors++;
                return;
            end
            want = pending_edges.pop_front();
            compare_field("white_edge", 8'(want.white_edge), 8'(got.white_edge));
            compare_field("gray_edge", 8'(want.gray_edge), 8'(got.gray_edge));
            compare_field("out_x", 8'(want.out_x), 8'(got.out_x));
            compare_field("out_y", 8'(want.out_y), 8'(got.out_y));
            compare_field("out_z", want.out_z, got.out_z);
            compare_field("last_voxel", 8'(want.last_voxel), 8'(got.last_voxel));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic                 action;
    logic                 white_voxel;
    logic                 gray_voxel;
    logic                 result_valid;
    logic                 result_stall;
    logic                 white_edge;
    logic                 gray_edge;
    tbv6_pkg::out_x_t     out_x;
    tbv6_pkg::out_y_t     out_y;
    tbv6_pkg::out_z_t     out_z;
    logic                 last_voxel;
    logic                 cfg_valid;
    logic                 cfg_ready;
    tbv6_pkg::cfg_index_t cfg_index;
    tbv6_pkg::cfg_data_t  cfg_data;

    boundary_checker sb;
    int unsigned     cycle_count = 0;
    int unsigned     stimulus_count = 0;
    int unsigned     gap_odds = 0;
    int unsigned     hold_requests = 0;
    bit              quiet = 1'b0;

    tissue_boundary_volume_6n_top #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .action(action),
        .white_voxel(white_voxel),
        .gray_voxel(gray_voxel),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .white_edge(white_edge),
        .gray_edge(gray_edge),
        .out_x(out_x),
        .out_y(out_y),
        .out_z(out_z),
        .last_voxel(last_voxel),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin : result_monitor
        edge_result_t seen;
        if (rst_n && result_valid && !result_stall)
        begin
            seen.white_edge = white_edge;
            seen.gray_edge  = gray_edge;
            seen.out_x      = out_x;
            seen.out_y      = out_y;
            seen.out_z      = out_z;
            seen.last_voxel = last_voxel;
            sb.check_result(seen);
        end
    end

    // Result side: random stall bursts in phases of varying density, plus one long hold.
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned stall_odds;
        int unsigned phase_left;
        int unsigned holds_done;
        stall_left = 0;
        stall_odds = 0;
        phase_left = 0;
        holds_done = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (phase_left == 0)
            begin
                phase_left = 150;
                stall_odds = $urandom_range(0, 5);
            end
            phase_left--;
            if (stall_left == 0 && !quiet && $urandom_range(0, 15) < stall_odds)
                stall_left = $urandom_range(1, 14);
            if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic act, input logic white, input logic gray);
        if (!quiet && gap_odds != 0 && $urandom_range(0, 15) < gap_odds)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item_valid  <= 1'b1;
        action      <= act;
        white_voxel <= white;
        gray_voxel  <= gray;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_request(act, white, gray);
        stimulus_count++;
        quiet = (stimulus_count + QUIET_TAIL >= ITEM_TARGET);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // Ignored requests leave no result behind, so give the pipeline time to empty.
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input tbv6_pkg::cfg_index_t idx,
                                  input tbv6_pkg::cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_register(idx, val);
        @(posedge clk);
    endtask

    task automatic set_volume(input tbv6_pkg::cfg_data_t sx, input tbv6_pkg::cfg_data_t sy,
                              input tbv6_pkg::cfg_data_t sz);
        wait_idle();
        write_register(tbv6_pkg::REG_SIZE_X, sx);
        write_register(tbv6_pkg::REG_SIZE_Y, sy);
        write_register(tbv6_pkg::REG_SIZE_Z, sz);
    endtask

    // One full volume with random labels, sprinkled with requests the block must ignore.
    task automatic run_volume(input tbv6_pkg::cfg_data_t sx, input tbv6_pkg::cfg_data_t sy,
                              input tbv6_pkg::cfg_data_t sz, input bit configure,
                              input bit squeeze);
        int unsigned voxels;
        int unsigned drains;
        int unsigned white_pct;
        int unsigned gray_pct;
        if (configure)
            set_volume(sx, sy, sz);
        drains = sb.span(tbv6_pkg::REG_SIZE_X) * sb.span(tbv6_pkg::REG_SIZE_Y);
        voxels = drains * sb.span(tbv6_pkg::REG_SIZE_Z);
        white_pct = 25 * $urandom_range(0, 4);
        gray_pct = 25 * $urandom_range(0, 4);
        gap_odds = squeeze ? 0 : $urandom_range(0, 6);
        if (squeeze)
            hold_requests++;
        for (int i = 0; i < voxels; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_request(tbv6_pkg::ACT_DRAIN, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            send_request(tbv6_pkg::ACT_VOXEL, $urandom_range(0, 99) < white_pct,
                         $urandom_range(0, 99) < gray_pct);
        end
        for (int i = 0; i < drains; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_request(tbv6_pkg::ACT_VOXEL, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            send_request(tbv6_pkg::ACT_DRAIN, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : stimulus
        bit fresh;
        sb = new();
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        action      <= tbv6_pkg::ACT_VOXEL;
        white_voxel <= 1'b0;
        gray_voxel  <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= tbv6_pkg::REG_SIZE_X;
        cfg_data    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single slice; the x write carries a ninth bit that the register drops and a zero
        // depth acts as one. A drain before the volume is complete and a voxel after it are
        // both ignored.
        set_volume(9'h102, 9'd1, 9'd0);
        send_request(tbv6_pkg::ACT_DRAIN, 1'b1, 1'b1);
        send_request(tbv6_pkg::ACT_VOXEL, 1'b1, 1'b0);
        send_request(tbv6_pkg::ACT_VOXEL, 1'b1, 1'b1);
        send_request(tbv6_pkg::ACT_VOXEL, 1'b0, 1'b1);
        send_request(tbv6_pkg::ACT_DRAIN, 1'b0, 1'b0);
        send_request(tbv6_pkg::ACT_DRAIN, 1'b1, 1'b0);

        wait_idle();
        write_register(REG_UNUSED, 9'h1FF);

        // Three slices, with the row width shrunk at a slice boundary mid-volume.
        set_volume(9'd3, 9'd2, 9'd3);
        for (int i = 0; i < 12; i++)
            send_request(tbv6_pkg::ACT_VOXEL, i[0], i[1]);
        wait_idle();
        write_register(tbv6_pkg::REG_SIZE_X, 9'd2);
        for (int i = 0; i < 4; i++)
            send_request(tbv6_pkg::ACT_VOXEL, i[0], !i[1]);
        for (int i = 0; i < 4; i++)
            send_request(tbv6_pkg::ACT_DRAIN, i[1], i[0]);

        // Size extremes: oversized width, full height, oversized depth under a long hold.
        run_volume(9'd255, 9'd1, 9'd1, 1'b1, 1'b0);
        run_volume(9'd1, 9'd128, 9'd1, 1'b1, 1'b0);
        run_volume(9'd1, 9'd1, 9'd511, 1'b1, 1'b1);

        fresh = 1'b1;
        while (stimulus_count < ITEM_TARGET)
        begin : one_volume
            tbv6_pkg::cfg_data_t sx;
            tbv6_pkg::cfg_data_t sy;
            tbv6_pkg::cfg_data_t sz;
            sx = tbv6_pkg::cfg_data_t'($urandom_range(1, 6));
            sy = tbv6_pkg::cfg_data_t'($urandom_range(1, 5));
            sz = tbv6_pkg::cfg_data_t'($urandom_range(1, 6));
            case ($urandom_range(0, 15))
                0: sx = '0;
                1: sy = '0;
                2: sz = '0;
                3:
                begin
                    sx = tbv6_pkg::cfg_data_t'($urandom_range(1, 2));
                    sy = 9'd1;
                    sz = tbv6_pkg::cfg_data_t'($urandom_range(7, 40));
                end
                4:
                begin
                    sx = tbv6_pkg::cfg_data_t'($urandom_range(7, 40));
                    sy = tbv6_pkg::cfg_data_t'($urandom_range(1, 2));
                end
                default: ;
            endcase
            run_volume(sx, sy, sz, fresh || $urandom_range(0, 3) != 0, 1'b0);
            fresh = 1'b0;
        end

        wait_idle();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
